### rtl/vma_pkg.sv
package vma_pkg;

	localparam int CFG_W  = 7;
	localparam int COL_W  = 6;
	localparam int DATA_W = 32;
	localparam int SUM_W  = 64;

	localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	typedef struct packed {
		logic signed [DATA_W-1:0] matrix_value;
		logic signed [DATA_W-1:0] vector_value;
		logic                     final_element;
	} in_item_t;

	typedef struct packed {
		logic [COL_W-1:0]        column_index;
		logic signed [SUM_W-1:0] dot_value;
		logic                    last_column;
	} out_item_t;

	function automatic logic signed [SUM_W-1:0] sat_add(
		input logic signed [SUM_W-1:0] a,
		input logic signed [SUM_W-1:0] b
	);
		logic signed [SUM_W-1:0] s;
		s = a + b;
		if (a[SUM_W-1] == b[SUM_W-1] && s[SUM_W-1] != a[SUM_W-1]) begin
			s = a[SUM_W-1] ? SUM_MIN : SUM_MAX;
		end
		return s;
	endfunction

endpackage

### rtl/vma_front.sv
module vma_front import vma_pkg::*; #(
	parameter int CW = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  in_item_t            in_data,
	input  logic [CFG_W-1:0]    n_cols,
	output logic                push,
	input  logic                full,
	output logic [SUM_W+CW:0]   push_data
);

	logic signed [DATA_W-1:0] m_s1;
	logic signed [DATA_W-1:0] v_s1;
	logic                     fin_s1;
	logic [CW-1:0]            col_s1;
	logic                     vld_s1;
	logic [CW-1:0]            pos_q;
	logic [CW-1:0]            cur;
	logic [CFG_W-1:0]         nxt;
	logic                     accept;
	logic signed [SUM_W-1:0]  prod;

	assign in_ready = !vld_s1 || !full;
	assign accept   = in_valid && in_ready;
	assign push     = vld_s1 && !full;

	always_comb begin
		cur = pos_q;
		if (CFG_W'(pos_q) >= n_cols) begin
			cur = '0;
		end
		nxt = CFG_W'(cur) + CFG_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			pos_q  <= '0;
		end else begin
			if (accept) begin
				vld_s1 <= 1'b1;
				if (in_data.final_element || nxt >= n_cols) begin
					pos_q <= '0;
				end else begin
					pos_q <= nxt[CW-1:0];
				end
			end else if (push) begin
				vld_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_s1   <= in_data.matrix_value;
			v_s1   <= in_data.vector_value;
			fin_s1 <= in_data.final_element;
			col_s1 <= cur;
		end
	end

	assign prod      = m_s1 * v_s1;
	assign push_data = {fin_s1, col_s1, prod};

endmodule

### rtl/vma_queue.sv
module vma_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic         empty,
	output logic [W-1:0] pop_data
);

	localparam int DEPTH = 4;
	localparam int AW    = 2;

	logic [W-1:0]  slot_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [AW:0]   cnt_q;

	assign full     = cnt_q == (AW+1)'(DEPTH);
	assign empty    = cnt_q == '0;
	assign pop_data = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (AW+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (AW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

endmodule

### rtl/vma_back.sv
module vma_back import vma_pkg::*; #(
	parameter int CW    = 6,
	parameter int DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [CFG_W-1:0]  n_cols,
	input  logic              empty,
	output logic              pop,
	input  logic [SUM_W+CW:0] pop_data,
	output logic              out_valid,
	input  logic              out_ready,
	output out_item_t         out_data
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ACC  = 3'd1;
	localparam logic [2:0] S_ERD  = 3'd2;
	localparam logic [2:0] S_ELD  = 3'd3;

	logic [2:0]              state_q;
	logic signed [SUM_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]        live_q;
	logic signed [SUM_W-1:0] rd_q;
	logic                    rdv_q;
	logic signed [SUM_W-1:0] prod_q;
	logic [CW-1:0]           col_q;
	logic                    fin_q;
	logic [CW-1:0]           k_q;
	logic                    ov_q;
	out_item_t               out_q;
	logic                    rd_en;
	logic [CW-1:0]           rd_addr;
	logic                    wr_en;
	logic signed [SUM_W-1:0] base;
	logic signed [SUM_W-1:0] sum;
	logic                    last;
	logic                    load;

	assign pop     = state_q == S_IDLE && !empty;
	assign rd_en   = pop || state_q == S_ERD;
	assign rd_addr = (state_q == S_ERD) ? k_q : pop_data[SUM_W +: CW];
	assign wr_en   = state_q == S_ACC;
	assign base    = rdv_q ? rd_q : '0;
	assign sum     = sat_add(base, prod_q);
	assign last    = CFG_W'(k_q) + CFG_W'(1) == n_cols;
	assign load    = state_q == S_ELD && (!ov_q || out_ready);

	assign out_valid = ov_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			live_q  <= '0;
			k_q     <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (load) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					live_q[col_q] <= 1'b1;
					k_q           <= '0;
					state_q       <= fin_q ? S_ERD : S_IDLE;
				end
				S_ERD: begin
					state_q <= S_ELD;
				end
				S_ELD: begin
					if (load) begin
						if (last) begin
							live_q  <= '0;
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q + CW'(1);
							state_q <= S_ERD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			prod_q <= pop_data[SUM_W-1:0];
			col_q  <= pop_data[SUM_W +: CW];
			fin_q  <= pop_data[SUM_W+CW];
		end
		if (rd_en) begin
			rd_q  <= mem[rd_addr];
			rdv_q <= live_q[rd_addr];
		end
		if (wr_en) begin
			mem[col_q] <= sum;
		end
		if (load) begin
			out_q.column_index <= COL_W'(k_q);
			out_q.dot_value    <= base;
			out_q.last_column  <= last;
		end
	end

endmodule

### rtl/vector_matrix_accumulate_core.sv
// Flow: an element is registered in the front stage, passes the queue and is popped by the
// back end, which reads its accumulator, adds the product and writes the sum back; after a
// final element it reads out each column in use in turn, holding while the output stalls.
// The back end takes no new element before that read-add-write is done, nor during a read-out.
// Reset: clears control state, the column position and the accumulator valid bits, and
// sets columns_in_use to 64; no clearing pass, the block accepts right after reset.
module vector_matrix_accumulate_core import vma_pkg::*; #(
	parameter int MAX_COLUMNS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_data,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata
);

	localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int QW = SUM_W + CW + 1;
	localparam logic [CFG_W-1:0] MAXC = CFG_W'(MAX_COLUMNS);

	logic [CFG_W-1:0] cfg_q;
	logic [CFG_W-1:0] n_cols;
	logic             push;
	logic             full;
	logic             pop;
	logic             empty;
	logic [QW-1:0]    push_data;
	logic [QW-1:0]    pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	always_comb begin
		n_cols = cfg_q;
		if (cfg_q == '0) begin
			n_cols = CFG_W'(1);
		end else if (cfg_q > MAXC) begin
			n_cols = MAXC;
		end
	end

	vma_front #(
		.CW(CW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.n_cols   (n_cols),
		.push     (push),
		.full     (full),
		.push_data(push_data)
	);

	vma_queue #(
		.W(QW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (full),
		.pop      (pop),
		.empty    (empty),
		.pop_data (pop_data)
	);

	vma_back #(
		.CW   (CW),
		.DEPTH(MAX_COLUMNS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.n_cols   (n_cols),
		.empty    (empty),
		.pop      (pop),
		.pop_data (pop_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule
